@@ hdl/rcj_pkg.sv @@
`timescale 1ns / 1ps
// shared constants and codes for the rc channel to joystick report block
// no dependencies

package rcj_pkg;

  // action codes of an input item
  typedef enum logic [1:0] {
    ACT_FRAME      = 2'd0,
    ACT_TICK       = 2'd1,
    ACT_SET_REPORT = 2'd2
  } action_t;

  localparam int unsigned NUM_CHAN = 8;
  localparam int unsigned NUM_BYTE = 8;

  // channel scaling: ((raw - 1480) * 255) / 1540, saturated at 255
  localparam logic [15:0] CHAN_OFFSET = 16'd1480;
  // first offset value whose scaled result exceeds 255
  localparam logic [15:0] SAT_LIMIT   = 16'd1547;
  // 255 * ceil(2^30 / 1540), exact for the operand range in use
  localparam logic [27:0] SCALE_MULT  = 28'd177794925;
  localparam int unsigned SCALE_SHIFT = 30;

  // button switch thresholds
  localparam logic [7:0] BTN_HIGH = 8'd196;
  localparam logic [7:0] BTN_MID  = 8'd64;

  localparam logic [7:0] HOLD_COUNT = 8'd250;

  // answer hash offsets by type
  localparam logic [7:0] HASH_OFS_0 = 8'h0D;
  localparam logic [7:0] HASH_OFS_1 = 8'h12;
  localparam logic [7:0] HASH_OFS_2 = 8'h10;
  localparam logic [7:0] HASH_OFS_3 = 8'h18;

  localparam logic [7:0] BYTE_FULL   = 8'hFF;
  localparam logic [7:0] BYTE_CENTRE = 8'h80;

  localparam logic [3:0] LEN_ANSWER   = 4'd8;
  localparam logic [3:0] LEN_JOYSTICK = 4'd7;

endpackage

@@ hdl/rcj_in_if.sv @@
`timescale 1ns / 1ps
// input channel: one radio frame, no-signal tick or host set-report per item
// no dependencies

interface rcj_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [15:0] chan_0;
  logic [15:0] chan_1;
  logic [15:0] chan_2;
  logic [15:0] chan_3;
  logic [15:0] chan_4;
  logic [15:0] chan_5;
  logic [15:0] chan_6;
  logic [15:0] chan_7;
  logic [63:0] host_report;

  modport source (output valid, action, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
                  chan_6, chan_7, host_report, input ready);
  modport sink   (input valid, action, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5,
                  chan_6, chan_7, host_report, output ready);
endinterface

@@ hdl/rcj_out_if.sv @@
`timescale 1ns / 1ps
// output channel: one joystick or answer report per item
// no dependencies

interface rcj_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] report_byte_0;
  logic [7:0] report_byte_1;
  logic [7:0] report_byte_2;
  logic [7:0] report_byte_3;
  logic [7:0] report_byte_4;
  logic [7:0] report_byte_5;
  logic [7:0] report_byte_6;
  logic [7:0] report_byte_7;
  logic [3:0] report_length;

  modport source (output valid, report_byte_0, report_byte_1, report_byte_2, report_byte_3,
                  report_byte_4, report_byte_5, report_byte_6, report_byte_7,
                  report_length, input ready);
  modport sink   (input valid, report_byte_0, report_byte_1, report_byte_2, report_byte_3,
                  report_byte_4, report_byte_5, report_byte_6, report_byte_7,
                  report_length, output ready);
endinterface

@@ hdl/rcj_cfg_if.sv @@
`timescale 1ns / 1ps
// configuration write channel carrying the report mode register
// no dependencies

interface rcj_cfg_if;
  logic valid;
  logic ready;
  logic answer_mode;

  modport source (output valid, answer_mode, input ready);
  modport sink   (input valid, answer_mode, output ready);
endinterface

@@ hdl/rcj_scale.sv @@
`timescale 1ns / 1ps
// maps one raw channel value onto a report byte
// depends on rcj_pkg

module rcj_scale (
  input  logic [15:0] raw,
  output logic [7:0]  scaled
);
  import rcj_pkg::*;

  logic [15:0] diff;
  logic [38:0] prod;

  always_comb begin
    diff = raw - CHAN_OFFSET;
    // divide by 1540 as a multiply by the reciprocal
    prod = 39'(diff[10:0]) * 39'(SCALE_MULT);
    if (raw < CHAN_OFFSET) begin
      scaled = 8'd0;
    end else if (diff >= SAT_LIMIT) begin
      scaled = BYTE_FULL;
    end else begin
      scaled = prod[SCALE_SHIFT +: 8];
    end
  end

endmodule

@@ hdl/rcj_answer.sv @@
`timescale 1ns / 1ps
// challenge answer byte from the eight host set-report bytes
// depends on rcj_pkg

module rcj_answer (
  input  logic [63:0] host_report,
  output logic [7:0]  answer
);
  import rcj_pkg::*;

  logic [7:0]  b [NUM_BYTE];
  logic [7:0]  b2_dec;
  logic [2:0]  kind;
  logic [10:0] sum;
  logic [10:0] sum_p8;
  logic [10:0] sum_p4;

  always_comb begin
    for (int i = 0; i < NUM_BYTE; i++) begin
      b[i] = host_report[8*i +: 8];
    end
    b2_dec = (b[2] != 8'd0) ? b[2] - 8'd1 : b[2];
    kind = b2_dec[7:5];

    case (kind)
      3'd0:    sum = 11'(b[6]);
      3'd1:    sum = 11'(b[3]);
      3'd2:    sum = 11'(b[4]) + 11'(b[5]);
      3'd3:    sum = 11'(b[1]) + 11'(b[6]);
      3'd4:    sum = 11'(b[0]) + 11'(b[7]);
      3'd5:    sum = 11'(b[5]) + 11'(b[6]);
      3'd6:    sum = 11'(b[0]) + 11'(b[1]) + 11'(b[3]) + 11'(b[4]);
      default: sum = 11'(b[0]) + 11'(b[1]) + 11'(b[3]) + 11'(b[4])
                   + 11'(b[5]) + 11'(b[6]) + 11'(b[7]);
    endcase

    sum_p8 = sum + 11'd8;
    sum_p4 = sum + 11'd4;

    // masks and shifts reduce to part-selects of the sum
    case (kind[1:0])
      2'd0:    answer = {1'b0, sum[3:0], 3'b000} + HASH_OFS_0;
      2'd1:    answer = {2'b00, sum[4:0], 1'b0} + HASH_OFS_1;
      2'd2:    answer = {3'b000, sum_p8[5:1]} + HASH_OFS_2;
      default: answer = {4'b0000, sum_p4[6:3]} + HASH_OFS_3;
    endcase
  end

endmodule

@@ hdl/rc_channels_to_hid_report.sv @@
`timescale 1ns / 1ps
// rc channel frames to joystick or challenge-answer report bytes
// depends on rcj_pkg, rcj_in_if, rcj_out_if, rcj_cfg_if, rcj_scale, rcj_answer
//
// Usage
//   in_ch  : one item per frame, no-signal tick or host set-report (action field)
//   out_ch : one report per frame or tick item; set-report and unused codes give none
//   cfg    : writes answer_mode (1 = 8-byte answer report, 0 = 7-byte joystick),
//            always ready; write only while no item is in flight
// Timing: an item is captured in the input register on acceptance; its report is
//   formed combinationally and captured in the result register, which drives out_ch.
// Throughput: one item per cycle unless out_ch stalls; channel scaling, button decode
//   and the answer hash each fit between the input and result registers.
// Stalls: the result register holds while out_ch.ready is low; one further item
//   waits in the input register, after which in_ch.ready drops until the
//   result is taken.
// Reset: synchronous; answer_mode returns to 1, the answer byte and hold count
//   clear, and both registers empty.

module rc_channels_to_hid_report (
  input  logic      clk,
  input  logic      rst,
  rcj_in_if.sink    in_ch,
  rcj_out_if.source out_ch,
  rcj_cfg_if.sink   cfg
);
  import rcj_pkg::*;

  // input register
  logic        s1_valid;
  logic [1:0]  s1_action;
  logic [15:0] s1_chan [NUM_CHAN];
  logic [63:0] s1_host;

  // result register
  logic        out_valid;
  logic [7:0]  rep [NUM_BYTE];
  logic [3:0]  rep_len;

  logic        answer_mode;
  logic [7:0]  answer_byte;
  logic [7:0]  hold_count;

  logic [7:0]  scaled [NUM_CHAN];
  logic [7:0]  answer_calc;
  logic [7:0]  rep_next [NUM_BYTE];
  logic [7:0]  answer_byte_next;
  logic [7:0]  hold_count_next;
  logic [7:0]  buttons;
  logic        res_make;
  logic        advance;
  logic        in_take;

  for (genvar g = 0; g < NUM_CHAN; g++) begin : g_scale
    rcj_scale u_scale (
      .raw    (s1_chan[g]),
      .scaled (scaled[g])
    );
  end

  rcj_answer u_answer (
    .host_report (s1_host),
    .answer      (answer_calc)
  );

  assign advance     = s1_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;

  always_comb begin
    buttons = 8'd0;
    if (scaled[6] > BTN_HIGH) begin
      buttons[0] = 1'b1;
    end else if (scaled[6] > BTN_MID) begin
      buttons[2] = 1'b1;
    end
    if (scaled[7] > BTN_HIGH) begin
      buttons[1] = 1'b1;
    end else if (scaled[7] > BTN_MID) begin
      buttons[3] = 1'b1;
    end
  end

  always_comb begin
    res_make         = 1'b0;
    answer_byte_next = answer_byte;
    hold_count_next  = hold_count;
    for (int i = 0; i < NUM_BYTE; i++) begin
      rep_next[i] = 8'd0;
    end
    case (s1_action)
      ACT_FRAME: begin
        res_make = 1'b1;
        if (answer_mode) begin
          rep_next[0] = scaled[0];
          rep_next[1] = answer_byte;
          rep_next[2] = scaled[1];
          rep_next[3] = scaled[2];
          rep_next[4] = scaled[3];
          rep_next[5] = scaled[4];
          rep_next[6] = scaled[5];
        end else begin
          rep_next[0] = scaled[2];
          rep_next[1] = scaled[3];
          rep_next[2] = scaled[0];
          rep_next[3] = scaled[1];
          rep_next[4] = scaled[4];
          rep_next[5] = scaled[5];
          rep_next[6] = buttons;
        end
      end
      ACT_TICK: begin
        res_make = 1'b1;
        if (answer_mode) begin
          // answer byte clears when the hold runs out
          if (hold_count != 8'd0) begin
            hold_count_next = hold_count - 8'd1;
            if (hold_count == 8'd1) begin
              answer_byte_next = 8'd0;
            end
          end
          rep_next[0] = BYTE_FULL;
          rep_next[1] = answer_byte_next;
          rep_next[2] = BYTE_FULL;
          rep_next[3] = BYTE_FULL;
          rep_next[4] = BYTE_FULL;
        end else begin
          rep_next[1] = BYTE_CENTRE;
          rep_next[2] = BYTE_CENTRE;
          rep_next[3] = BYTE_CENTRE;
          rep_next[4] = BYTE_CENTRE;
          rep_next[5] = BYTE_CENTRE;
        end
      end
      ACT_SET_REPORT: begin
        answer_byte_next = answer_calc;
        hold_count_next  = HOLD_COUNT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      out_valid   <= 1'b0;
      answer_mode <= 1'b1;
      answer_byte <= 8'd0;
      hold_count  <= 8'd0;
    end else begin
      if (cfg.valid) begin
        answer_mode <= cfg.answer_mode;
      end

      if (in_take) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end

      if (advance) begin
        answer_byte <= answer_byte_next;
        hold_count  <= hold_count_next;
      end

      if (advance && res_make) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action  <= in_ch.action;
      s1_chan[0] <= in_ch.chan_0;
      s1_chan[1] <= in_ch.chan_1;
      s1_chan[2] <= in_ch.chan_2;
      s1_chan[3] <= in_ch.chan_3;
      s1_chan[4] <= in_ch.chan_4;
      s1_chan[5] <= in_ch.chan_5;
      s1_chan[6] <= in_ch.chan_6;
      s1_chan[7] <= in_ch.chan_7;
      s1_host    <= in_ch.host_report;
    end
    if (advance && res_make) begin
      rep     <= rep_next;
      rep_len <= answer_mode ? LEN_ANSWER : LEN_JOYSTICK;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.report_byte_0 = rep[0];
  assign out_ch.report_byte_1 = rep[1];
  assign out_ch.report_byte_2 = rep[2];
  assign out_ch.report_byte_3 = rep[3];
  assign out_ch.report_byte_4 = rep[4];
  assign out_ch.report_byte_5 = rep[5];
  assign out_ch.report_byte_6 = rep[6];
  assign out_ch.report_byte_7 = rep[7];
  assign out_ch.report_length = rep_len;

`ifndef SYNTHESIS
  // hold count only rearms to the full count or steps down by one
  a_hold_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(hold_count) |-> (hold_count == HOLD_COUNT
                              || hold_count == $past(hold_count) - 8'd1))
    else $error("hold count moved by an unexpected step");

  // the answer byte only clears at the end of a hold
  a_answer_clear: assert property (@(posedge clk) disable iff (rst)
    ($past(answer_byte) != 8'd0 && answer_byte == 8'd0 && $past(hold_count) != 8'd0)
      |-> (hold_count == 8'd0 && $past(hold_count) == 8'd1))
    else $error("answer byte cleared while the hold was running");

  // report length follows the mode, which the user changes only while idle (unenforced)
  a_len_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (rep_len == (answer_mode ? LEN_ANSWER : LEN_JOYSTICK)))
    else $error("report length does not match the report mode");

  // an empty result register never blocks the input side
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ch.ready)
    else $error("input stalled with no result pending");
`endif

endmodule

@@ verif/tb_rc_channels_to_hid_report.sv @@
`timescale 1ns / 1ps
// self-checking bench for rc_channels_to_hid_report: queued stimulus, random gaps and stalls,
// reports predicted per accepted item and compared field by field in arrival order
// depends on rcj_pkg, rcj_in_if, rcj_out_if, rcj_cfg_if and the block itself

module tb_rc_channels_to_hid_report;
  import rcj_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int GAP_PCT = 22;

  // sum selection of the answer hash, from the type field of host byte 2
  typedef enum logic [2:0] {
    HS_B6, HS_B3, HS_B45, HS_B16, HS_B07, HS_B56, HS_B0134, HS_ALL
  } hash_sel_t;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0][15:0]  chan;
    logic [63:0]       host;
  } in_item_t;

  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      len;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  rcj_in_if  in_ch ();
  rcj_out_if out_ch ();
  rcj_cfg_if cfg ();

  rc_channels_to_hid_report u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  always #6 clk = ~clk;

  in_item_t stim_q[$];
  report_t  report_q[$];

  // predictor copy of the block state
  logic       cur_mode = 1'b1;
  logic [7:0] cur_answer = '0;
  logic [7:0] cur_hold = '0;

  int err_count = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic in_taken = 1'b0;
  in_item_t drv_item;
  in_item_t mon_item;
  report_t got;

  task automatic report_mismatch(input string what, input logic [63:0] seen,
                                 input logic [63:0] want);
    if (err_count < 50)
      $display("%0t ns: %s: got %0h, expected %0h", $realtime, what, seen, want);
    err_count++;
  endtask

  function automatic logic [7:0] scale_raw(input logic [15:0] raw);
    int unsigned v;
    if (raw < CHAN_OFFSET) return '0;
    v = 32'(raw) - 32'(CHAN_OFFSET);
    v = (v * 255) / 1540;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] answer_of(input logic [63:0] host);
    logic [7:0] b [8];
    int unsigned t, sum, h;
    hash_sel_t sel;
    for (int i = 0; i < 8; i++) b[i] = host[8*i +: 8];
    t = b[2];
    if (t > 0) t--;
    sel = hash_sel_t'(t >> 5);
    case (sel)
      HS_B6:    sum = b[6];
      HS_B3:    sum = b[3];
      HS_B45:   sum = b[4] + b[5];
      HS_B16:   sum = b[1] + b[6];
      HS_B07:   sum = b[0] + b[7];
      HS_B56:   sum = b[5] + b[6];
      HS_B0134: sum = b[0] + b[1] + b[3] + b[4];
      default:  sum = b[0] + b[1] + b[3] + b[4] + b[5] + b[6] + b[7];
    endcase
    // hash variant follows the low two bits of the type
    case (sel)
      HS_B6, HS_B07:    h = ((sum * 8) & 'h7F) + HASH_OFS_0;
      HS_B3, HS_B56:    h = ((sum * 2) & 'h3F) + HASH_OFS_1;
      HS_B45, HS_B0134: h = (((sum + 8) / 2) & 'h1F) + HASH_OFS_2;
      default:          h = (((sum + 4) / 8) & 'h0F) + HASH_OFS_3;
    endcase
    return h[7:0];
  endfunction

  task automatic predict_item(input in_item_t it);
    report_t r;
    logic [7:0] s6, s7;
    r = '0;
    case (it.action)
      ACT_SET_REPORT: begin
        cur_answer = answer_of(it.host);
        cur_hold = HOLD_COUNT;
      end
      ACT_FRAME: begin
        if (cur_mode) begin
          r.bytes[0] = scale_raw(it.chan[0]);
          r.bytes[1] = cur_answer;
          for (int i = 1; i < 6; i++) r.bytes[i+1] = scale_raw(it.chan[i]);
        end else begin
          r.bytes[0] = scale_raw(it.chan[2]);
          r.bytes[1] = scale_raw(it.chan[3]);
          r.bytes[2] = scale_raw(it.chan[0]);
          r.bytes[3] = scale_raw(it.chan[1]);
          r.bytes[4] = scale_raw(it.chan[4]);
          r.bytes[5] = scale_raw(it.chan[5]);
          s6 = scale_raw(it.chan[6]);
          s7 = scale_raw(it.chan[7]);
          if (s6 > BTN_HIGH) r.bytes[6][0] = 1'b1;
          else if (s6 > BTN_MID) r.bytes[6][2] = 1'b1;
          if (s7 > BTN_HIGH) r.bytes[6][1] = 1'b1;
          else if (s7 > BTN_MID) r.bytes[6][3] = 1'b1;
        end
      end
      ACT_TICK: begin
        if (cur_mode) begin
          // hold runs down on no-signal ticks, answer clears when it expires
          if (cur_hold != 0) begin
            cur_hold--;
            if (cur_hold == 0) cur_answer = '0;
          end
          r.bytes[0] = BYTE_FULL;
          r.bytes[1] = cur_answer;
          r.bytes[2] = BYTE_FULL;
          r.bytes[3] = BYTE_FULL;
          r.bytes[4] = BYTE_FULL;
        end else begin
          for (int i = 1; i < 6; i++) r.bytes[i] = BYTE_CENTRE;
        end
      end
      default: ;
    endcase
    if (it.action == ACT_FRAME || it.action == ACT_TICK) begin
      r.len = cur_mode ? LEN_ANSWER : LEN_JOYSTICK;
      report_q.push_back(r);
    end
  endtask

  function automatic logic [15:0] pick_chan();
    logic [15:0] pts [12] = '{16'd0, 16'd1479, 16'd1480, 16'd1481, 16'd1872, 16'd1873,
                               16'd2669, 16'd2670, 16'd3026, 16'd3027, 16'd3028, 16'hFFFF};
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 4) return 16'($urandom_range(1400, 3100));
    if (k < 7) return 16'($urandom());
    return pts[$urandom_range(0, 11)];
  endfunction

  function automatic in_item_t make_item(input logic [1:0] act);
    in_item_t it;
    it.action = act;
    for (int i = 0; i < 8; i++) it.chan[i] = pick_chan();
    it.host = {$urandom(), $urandom()};
    return it;
  endfunction

  function automatic logic [1:0] rand_action(input int tick_pct, input int set_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 2) return ACT_UNUSED;
    if (r < 2 + set_pct) return ACT_SET_REPORT;
    if (r < 2 + set_pct + tick_pct) return ACT_TICK;
    return ACT_FRAME;
  endfunction

  // all queued items taken, all reports in, then room for items that give none
  task automatic wait_idle();
    while (stim_q.size() != 0 || in_ch.valid || report_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.answer_mode <= mode;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // item driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (stim_q.size() != 0 && (no_gaps || $urandom_range(0, 99) >= GAP_PCT)) begin
        drv_item = stim_q.pop_front();
        in_ch.action <= drv_item.action;
        in_ch.chan_0 <= drv_item.chan[0];
        in_ch.chan_1 <= drv_item.chan[1];
        in_ch.chan_2 <= drv_item.chan[2];
        in_ch.chan_3 <= drv_item.chan[3];
        in_ch.chan_4 <= drv_item.chan[4];
        in_ch.chan_5 <= drv_item.chan[5];
        in_ch.chan_6 <= drv_item.chan[6];
        in_ch.chan_7 <= drv_item.chan[7];
        in_ch.host_report <= drv_item.host;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // report receiver, with a long hold-off on request
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_OFF_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // monitor: register writes, accepted items and reports
  always @(posedge clk) begin
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_ch.valid && in_ch.ready;
      if (cfg.valid && cfg.ready) cur_mode = cfg.answer_mode;
      if (out_ch.valid && out_ch.ready) begin
        got.bytes = {out_ch.report_byte_7, out_ch.report_byte_6, out_ch.report_byte_5,
                     out_ch.report_byte_4, out_ch.report_byte_3, out_ch.report_byte_2,
                     out_ch.report_byte_1, out_ch.report_byte_0};
        got.len = out_ch.report_length;
        if (report_q.size() == 0) begin
          report_mismatch("report with none pending", got.bytes, '0);
        end else begin
          for (int i = 0; i < 8; i++)
            if (got.bytes[i] !== report_q[0].bytes[i])
              report_mismatch($sformatf("report_byte_%0d", i), got.bytes[i],
                              report_q[0].bytes[i]);
          if (got.len !== report_q[0].len)
            report_mismatch("report_length", got.len, report_q[0].len);
          void'(report_q.pop_front());
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        mon_item.action = in_ch.action;
        mon_item.chan = {in_ch.chan_7, in_ch.chan_6, in_ch.chan_5, in_ch.chan_4,
                         in_ch.chan_3, in_ch.chan_2, in_ch.chan_1, in_ch.chan_0};
        mon_item.host = in_ch.host_report;
        predict_item(mon_item);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_rc_channels_to_hid_report: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_item_t it;
    logic [7:0] type_b2 [9] = '{8'd0, 8'd1, 8'd33, 8'd65, 8'd97, 8'd129, 8'd161, 8'd193,
                                8'd255};
    logic [15:0] sw_a [5] = '{16'd1872, 16'd1873, 16'd2670, 16'd2669, 16'd0};
    logic [15:0] sw_b [5] = '{16'd2670, 16'd2669, 16'd1873, 16'd1872, 16'hFFFF};
    int ticks;

    cfg.valid = 1'b0;
    cfg.answer_mode = 1'b1;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // answer mode out of reset: channel extremes, every hash type, idle ticks
    it = make_item(ACT_FRAME);
    it.chan = '0;
    stim_q.push_back(it);
    it.chan = '1;
    stim_q.push_back(it);
    it.chan = {8{16'd1480}};
    stim_q.push_back(it);
    it.chan = {16'd3026, 16'd3027, 16'd3028, 16'd1479, 16'd1481, 16'd1873, 16'd2670,
               16'd1872};
    stim_q.push_back(it);
    stim_q.push_back(make_item(ACT_TICK));
    foreach (type_b2[i]) begin
      it = make_item(ACT_SET_REPORT);
      it.host[23:16] = type_b2[i];
      stim_q.push_back(it);
      stim_q.push_back(make_item(i % 2 ? ACT_TICK : ACT_FRAME));
    end
    it = make_item(ACT_SET_REPORT);
    it.host = '1;
    stim_q.push_back(it);
    stim_q.push_back(make_item(ACT_UNUSED));
    stim_q.push_back(make_item(ACT_FRAME));
    wait_idle();

    // joystick mode: switch positions either side of both thresholds
    write_mode(1'b0);
    foreach (sw_a[i]) begin
      it = make_item(ACT_FRAME);
      it.chan[6] = sw_a[i];
      it.chan[7] = sw_b[i];
      stim_q.push_back(it);
    end
    stim_q.push_back(make_item(ACT_TICK));
    stim_q.push_back(make_item(ACT_SET_REPORT));
    stim_q.push_back(make_item(ACT_TICK));
    stim_q.push_back(make_item(ACT_UNUSED));
    no_gaps = 1'b1;
    repeat (250) stim_q.push_back(make_item(rand_action(30, 8)));
    wait_idle();
    no_gaps = 1'b0;

    // answer mode: armed hold run down to expiry, while the receiver holds off
    write_mode(1'b1);
    stim_q.push_back(make_item(ACT_SET_REPORT));
    ticks = 0;
    while (ticks < 255) begin
      if ($urandom_range(0, 99) < 15) begin
        stim_q.push_back(make_item(ACT_FRAME));
      end else begin
        stim_q.push_back(make_item(ACT_TICK));
        ticks++;
      end
    end
    stim_q.push_back(make_item(ACT_FRAME));
    hold_req++;
    repeat (200) stim_q.push_back(make_item(rand_action(45, 10)));
    // re-arm part way through a count
    stim_q.push_back(make_item(ACT_SET_REPORT));
    repeat (100) stim_q.push_back(make_item(ACT_TICK));
    stim_q.push_back(make_item(ACT_SET_REPORT));
    repeat (30) stim_q.push_back(make_item(rand_action(40, 5)));
    wait_idle();

    write_mode(1'b0);
    repeat (100) stim_q.push_back(make_item(rand_action(30, 8)));
    wait_idle();
    repeat (8) @(posedge clk);

    if (report_q.size() != 0) report_mismatch("reports never delivered", 0, report_q.size());
    if (err_count == 0) begin
      $display("tb_rc_channels_to_hid_report: clean");
    end else begin
      $display("tb_rc_channels_to_hid_report: errors");
    end
    $finish;
  end

endmodule

@@ rc_channels_to_hid_report.f @@
hdl/rcj_pkg.sv
hdl/rcj_in_if.sv
hdl/rcj_out_if.sv
hdl/rcj_cfg_if.sv
hdl/rcj_scale.sv
hdl/rcj_answer.sv
hdl/rc_channels_to_hid_report.sv
verif/tb_rc_channels_to_hid_report.sv
